@@ sv/pte_pkg.sv @@
// Shared types and codes for the process table engine.
// No dependencies; used by pte_cell and process_table_engine.
`default_nettype none

package pte_pkg;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_TOGGLE = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_LIST   = 2'd3;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_FULL      = 2'd1;
  localparam logic [1:0] STS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STS_EMPTY     = 2'd3;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] run_time;
    logic        paused;
  } entry_t;

  // per-cycle commands broadcast to every cell of the chain
  typedef struct packed {
    logic rotate;   // every cell takes its upper neighbour
    logic compact;  // cells at or above sel_pos take their upper neighbour
    logic load;     // cell at sel_pos takes the new entry
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMPACT
  } pte_state_t;

endpackage

`default_nettype wire

@@ sv/pte_cell.sv @@
// One table slot of the entry chain: loads an entry or takes its upper neighbour's.
// Depends on pte_pkg.
`default_nettype none

module pte_cell #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  wire logic                clk,
  input  wire pte_pkg::cell_ctl_t  ctl,
  input  wire logic [IW-1:0]       sel_pos,
  input  wire pte_pkg::entry_t     nbr_in,
  input  wire pte_pkg::entry_t     load_in,
  output pte_pkg::entry_t          q
);

  pte_pkg::entry_t entry_r;
  logic            at_pos;
  logic            above_pos;

  assign at_pos    = (IW'(IDX) == sel_pos);
  assign above_pos = (IW'(IDX) >= sel_pos);

  always_ff @(posedge clk) begin
    if (ctl.load && at_pos) begin
      entry_r <= load_in;
    end else if (ctl.rotate || (ctl.compact && above_pos)) begin
      entry_r <= nbr_in;
    end
  end

  assign q = entry_r;

endmodule

`default_nettype wire

@@ sv/process_table_engine.sv @@
// Process table engine top level: control sequencer around a ring of entry cells.
// Depends on pte_pkg and pte_cell.
`default_nettype none

// Usage
//   Commands go in on start/in_cmd/in_target_id/in_run_time; one is taken at a
//   rising edge with start high and busy low. Results leave on out_* with
//   out_valid high for one cycle each; out_last_result marks the final result
//   of a command. The receiver cannot hold results off.
// Timing
//   Add, and any command on an empty table (or add on a full one), answers on
//   the cycle after acceptance and leaves busy low: one item per cycle.
//   Toggle, remove and list rotate the whole cell ring once, one slot a cycle,
//   reading each entry as it passes the head cell; busy stays high for the whole
//   rotation, and a remove that finds its entry then passes through the
//   compaction state before busy falls. Results appear during the rotation,
//   list results one per cycle in table order.
// Reset
//   Synchronous, active low; empties the table. Slot contents are not cleared
//   and are never read before being written.
module process_table_engine #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_target_id,
  input  wire logic [15:0] in_run_time,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [7:0]       out_entry_id,
  output logic [15:0]      out_entry_time,
  output logic             out_entry_paused,
  output logic             out_last_result
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  pte_pkg::pte_state_t state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [IW-1:0]       step_r, step_nxt;
  logic [IW-1:0]       pos_r, pos_nxt;
  logic                found_r, found_nxt;
  logic [1:0]          cmd_r, cmd_nxt;
  logic [7:0]          tid_r, tid_nxt;

  logic                ov_r, ov_nxt;
  logic [1:0]          sts_r, sts_nxt;
  logic [7:0]          oid_r, oid_nxt;
  logic [15:0]         otime_r, otime_nxt;
  logic                opaused_r, opaused_nxt;
  logic                olast_r, olast_nxt;

  pte_pkg::cell_ctl_t  ctl;
  logic [IW-1:0]       sel_pos;
  logic                flip;
  pte_pkg::entry_t     cell_q [MAX_ENTRIES];
  pte_pkg::entry_t     nbr    [MAX_ENTRIES];
  pte_pkg::entry_t     head;
  pte_pkg::entry_t     tail;
  pte_pkg::entry_t     new_entry;

  logic                accept;
  logic                in_range;
  logic                last_ent;
  logic                hit;
  logic                full;
  logic                empty;
  logic                scan_done;

  assign busy      = (state_r != pte_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign full      = (cnt_r == CW'(MAX_ENTRIES));
  assign empty     = (cnt_r == '0);
  assign head      = cell_q[0];
  assign in_range  = (CW'(step_r) < cnt_r);
  assign last_ent  = (CW'(step_r) == (cnt_r - 1'b1));
  assign scan_done = (step_r == IW'(MAX_ENTRIES - 1));
  assign hit       = (state_r == pte_pkg::ST_SCAN) && (cmd_r != pte_pkg::CMD_LIST) &&
                     in_range && !found_r && (head.id == tid_r);

  // toggled flag is written back as the head entry wraps to the tail
  assign flip = hit && (cmd_r == pte_pkg::CMD_TOGGLE);
  always_comb begin
    tail        = head;
    tail.paused = head.paused ^ flip;
  end

  assign new_entry = '{id: 8'(cnt_r) + 8'd1, run_time: in_run_time, paused: 1'b0};
  assign sel_pos   = (state_r == pte_pkg::ST_COMPACT) ? pos_r : cnt_r[IW-1:0];

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    if (k == MAX_ENTRIES - 1) begin : g_tail
      assign nbr[k] = tail;
    end else begin : g_mid
      assign nbr[k] = cell_q[k+1];
    end
    pte_cell #(
      .IW  (IW),
      .IDX (k)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .sel_pos (sel_pos),
      .nbr_in  (nbr[k]),
      .load_in (new_entry),
      .q       (cell_q[k])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pte_pkg::ST_IDLE: begin
        if (accept && !empty && (in_cmd != pte_pkg::CMD_ADD)) begin
          state_nxt = pte_pkg::ST_SCAN;
        end
      end
      pte_pkg::ST_SCAN: begin
        if (scan_done) begin
          if ((cmd_r == pte_pkg::CMD_REMOVE) && (found_r || hit)) begin
            state_nxt = pte_pkg::ST_COMPACT;
          end else begin
            state_nxt = pte_pkg::ST_IDLE;
          end
        end
      end
      pte_pkg::ST_COMPACT: begin
        state_nxt = pte_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pte_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs and datapath control
  always_comb begin
    ctl         = '0;
    cnt_nxt     = cnt_r;
    step_nxt    = step_r;
    pos_nxt     = pos_r;
    found_nxt   = found_r;
    cmd_nxt     = cmd_r;
    tid_nxt     = tid_r;
    ov_nxt      = 1'b0;
    sts_nxt     = pte_pkg::STS_OK;
    oid_nxt     = '0;
    otime_nxt   = '0;
    opaused_nxt = 1'b0;
    olast_nxt   = 1'b1;
    unique case (state_r)
      pte_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_cmd;
          tid_nxt   = in_target_id;
          step_nxt  = '0;
          found_nxt = 1'b0;
          case (in_cmd) inside
            pte_pkg::CMD_ADD: begin
              ov_nxt = 1'b1;
              if (full) begin
                sts_nxt = pte_pkg::STS_FULL;
              end else begin
                ctl.load  = 1'b1;
                cnt_nxt   = cnt_r + 1'b1;
                oid_nxt   = new_entry.id;
                otime_nxt = in_run_time;
              end
            end
            pte_pkg::CMD_TOGGLE, pte_pkg::CMD_REMOVE: begin
              if (empty) begin
                ov_nxt  = 1'b1;
                sts_nxt = pte_pkg::STS_NOT_FOUND;
                oid_nxt = in_target_id;
              end
            end
            default: begin
              if (empty) begin
                ov_nxt  = 1'b1;
                sts_nxt = pte_pkg::STS_EMPTY;
              end
            end
          endcase
        end
      end
      pte_pkg::ST_SCAN: begin
        ctl.rotate = 1'b1;
        step_nxt   = step_r + 1'b1;
        if (cmd_r == pte_pkg::CMD_LIST) begin
          if (in_range) begin
            ov_nxt      = 1'b1;
            oid_nxt     = head.id;
            otime_nxt   = head.run_time;
            opaused_nxt = head.paused;
            olast_nxt   = last_ent;
          end
        end else if (hit) begin
          found_nxt   = 1'b1;
          pos_nxt     = step_r;
          ov_nxt      = 1'b1;
          oid_nxt     = head.id;
          otime_nxt   = head.run_time;
          opaused_nxt = tail.paused;
        end else if (last_ent && !found_r) begin
          ov_nxt  = 1'b1;
          sts_nxt = pte_pkg::STS_NOT_FOUND;
          oid_nxt = tid_r;
        end
      end
      pte_pkg::ST_COMPACT: begin
        ctl.compact = 1'b1;
        cnt_nxt     = cnt_r - 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pte_pkg::ST_IDLE;
      cnt_r   <= '0;
      found_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r    <= step_nxt;
    pos_r     <= pos_nxt;
    cmd_r     <= cmd_nxt;
    tid_r     <= tid_nxt;
    sts_r     <= sts_nxt;
    oid_r     <= oid_nxt;
    otime_r   <= otime_nxt;
    opaused_r <= opaused_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_valid        = ov_r;
  assign out_status       = sts_r;
  assign out_entry_id     = oid_r;
  assign out_entry_time   = otime_r;
  assign out_entry_paused = opaused_r;
  assign out_last_result  = olast_r;

`ifndef SYNTH
  a_add_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd == pte_pkg::CMD_ADD)) |=> (out_valid && out_last_result))
    else $error("add item gave no single result");

  a_compact_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pte_pkg::ST_COMPACT) |-> ($past(state_r) == pte_pkg::ST_SCAN))
    else $error("compaction entered without a scan");

  a_compact_drops_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pte_pkg::ST_COMPACT) |=> (cnt_r == CW'($past(cnt_r) - 1'b1)))
    else $error("remove did not drop exactly one entry");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CW'(MAX_ENTRIES)))
    else $error("entry count beyond table size");
`endif

endmodule

`default_nettype wire

@@ sim/process_table_engine_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for process_table_engine: directed and random command items
// checked field by field against a table model kept in the bench.
// Depends on pte_pkg and the process_table_engine RTL.
module process_table_engine_tb;

  localparam int MAX_ENTRIES = 16;
  localparam int N_RANDOM    = 150;
  localparam int IDLE_LIMIT  = 1000;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  target_id;
    logic [15:0] run_time;
    int          gap;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  entry_id;
    logic [15:0] entry_time;
    logic        entry_paused;
    logic        last_result;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  in_cmd = pte_pkg::CMD_LIST;
  logic [7:0]  in_target_id = 8'd0;
  logic [15:0] in_run_time = 16'd0;
  logic        busy;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [7:0]  out_entry_id;
  logic [15:0] out_entry_time;
  logic        out_entry_paused;
  logic        out_last_result;

  cmd_item_t     cmd_queue[$];
  table_result_t expected_results[$];

  // bench copy of the process table
  logic [7:0]  tbl_id     [MAX_ENTRIES];
  logic [15:0] tbl_time   [MAX_ENTRIES];
  logic        tbl_paused [MAX_ENTRIES];
  int          tbl_count = 0;

  int error_count = 0;
  int idle_cycles = 0;
  int gap_left = 0;

  process_table_engine #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cmd(in_cmd),
    .in_target_id(in_target_id),
    .in_run_time(in_run_time),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_entry_id(out_entry_id),
    .out_entry_time(out_entry_time),
    .out_entry_paused(out_entry_paused),
    .out_last_result(out_last_result)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void push_result(input logic [1:0] status, input logic [7:0] id,
                                      input logic [15:0] run_time, input logic paused,
                                      input logic last);
    table_result_t r;
    r.status       = status;
    r.entry_id     = id;
    r.entry_time   = run_time;
    r.entry_paused = paused;
    r.last_result  = last;
    expected_results.push_back(r);
  endfunction

  // updates the table for one accepted item and queues the results it causes
  function automatic void apply_command(input logic [1:0] cmd, input logic [7:0] tid,
                                        input logic [15:0] run_time);
    int hit;
    hit = -1;
    case (cmd)
      pte_pkg::CMD_ADD: begin
        if (tbl_count >= MAX_ENTRIES) begin
          push_result(pte_pkg::STS_FULL, 8'd0, 16'd0, 1'b0, 1'b1);
        end else begin
          // id follows the count, so it may repeat after a removal
          tbl_id[tbl_count]     = 8'(tbl_count + 1);
          tbl_time[tbl_count]   = run_time;
          tbl_paused[tbl_count] = 1'b0;
          push_result(pte_pkg::STS_OK, tbl_id[tbl_count], run_time, 1'b0, 1'b1);
          tbl_count++;
        end
      end
      pte_pkg::CMD_TOGGLE, pte_pkg::CMD_REMOVE: begin
        for (int i = tbl_count - 1; i >= 0; i--) begin
          if (tbl_id[i] == tid) hit = i;
        end
        if (hit < 0) begin
          push_result(pte_pkg::STS_NOT_FOUND, tid, 16'd0, 1'b0, 1'b1);
        end else begin
          if (cmd == pte_pkg::CMD_TOGGLE) tbl_paused[hit] = ~tbl_paused[hit];
          push_result(pte_pkg::STS_OK, tbl_id[hit], tbl_time[hit], tbl_paused[hit], 1'b1);
          if (cmd == pte_pkg::CMD_REMOVE) begin
            for (int i = hit; i < tbl_count - 1; i++) begin
              tbl_id[i]     = tbl_id[i + 1];
              tbl_time[i]   = tbl_time[i + 1];
              tbl_paused[i] = tbl_paused[i + 1];
            end
            tbl_count--;
          end
        end
      end
      pte_pkg::CMD_LIST: begin
        if (tbl_count == 0) begin
          push_result(pte_pkg::STS_EMPTY, 8'd0, 16'd0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < tbl_count; i++) begin
            push_result(pte_pkg::STS_OK, tbl_id[i], tbl_time[i], tbl_paused[i],
                        (i == tbl_count - 1) ? 1'b1 : 1'b0);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_cmd(input logic [1:0] cmd, input logic [7:0] tid,
                                    input logic [15:0] run_time, input int gap);
    cmd_item_t it;
    it.cmd       = cmd;
    it.target_id = tid;
    it.run_time  = run_time;
    it.gap       = gap;
    cmd_queue.push_back(it);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // driver: holds an item until taken, then waits out the next item's gap
  always @(posedge clk) begin : driver
    cmd_item_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_command(in_cmd, in_target_id, in_run_time);
        if (cmd_queue.size() != 0) gap_left = cmd_queue[0].gap;
      end
      if (start && busy) begin
        // item still waiting to be taken
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        nxt = cmd_queue.pop_front();
        start        <= 1'b1;
        in_cmd       <= nxt.cmd;
        in_target_id <= nxt.target_id;
        in_run_time  <= nxt.run_time;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    table_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d, id %0d", out_status, out_entry_id);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 16'(want.status), 16'(out_status));
        check_field("entry_id", 16'(want.entry_id), 16'(out_entry_id));
        check_field("entry_time", want.entry_time, out_entry_time);
        check_field("entry_paused", 16'(want.entry_paused), 16'(out_entry_paused));
        check_field("last_result", 16'(want.last_result), 16'(out_last_result));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : stimulus
    int          mix;
    int          roll;
    bit          no_gaps;
    logic [1:0]  c;
    logic [7:0]  tid;
    logic [15:0] rt;

    mix     = 0;
    no_gaps = 1'b0;

    // empty table, extremes of run_time, duplicate ids after a removal
    queue_cmd(pte_pkg::CMD_LIST, 8'd0, 16'd0, pick_gap());
    queue_cmd(pte_pkg::CMD_REMOVE, 8'd255, 16'hffff, pick_gap());
    queue_cmd(pte_pkg::CMD_TOGGLE, 8'd0, 16'd0, pick_gap());
    queue_cmd(pte_pkg::CMD_ADD, 8'd0, 16'd0, pick_gap());
    queue_cmd(pte_pkg::CMD_ADD, 8'hff, 16'hffff, pick_gap());
    queue_cmd(pte_pkg::CMD_TOGGLE, 8'd2, 16'd0, pick_gap());
    queue_cmd(pte_pkg::CMD_REMOVE, 8'd1, 16'd0, pick_gap());
    queue_cmd(pte_pkg::CMD_ADD, 8'd0, 16'h1234, pick_gap());
    queue_cmd(pte_pkg::CMD_TOGGLE, 8'd2, 16'd0, pick_gap());
    queue_cmd(pte_pkg::CMD_REMOVE, 8'd2, 16'd0, pick_gap());
    // fill up, overflow, full list, remove at both ends
    for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
      queue_cmd(pte_pkg::CMD_ADD, 8'($urandom), 16'($urandom), 0);
    end
    queue_cmd(pte_pkg::CMD_ADD, 8'd0, 16'hffff, pick_gap());
    queue_cmd(pte_pkg::CMD_LIST, 8'd0, 16'd0, pick_gap());
    queue_cmd(pte_pkg::CMD_REMOVE, 8'(MAX_ENTRIES), 16'd0, pick_gap());
    queue_cmd(pte_pkg::CMD_REMOVE, 8'd2, 16'd0, pick_gap());
    queue_cmd(pte_pkg::CMD_LIST, 8'd0, 16'd0, pick_gap());

    // random part in runs that lean towards filling, draining or neither
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 15 == 0) begin
        mix     = $urandom_range(0, 3);
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      case (mix)
        0: c = (roll < 65) ? pte_pkg::CMD_ADD : (roll < 78) ? pte_pkg::CMD_TOGGLE :
               (roll < 88) ? pte_pkg::CMD_REMOVE : pte_pkg::CMD_LIST;
        1: c = (roll < 15) ? pte_pkg::CMD_ADD : (roll < 35) ? pte_pkg::CMD_TOGGLE :
               (roll < 80) ? pte_pkg::CMD_REMOVE : pte_pkg::CMD_LIST;
        default: c = 2'($urandom_range(0, 3));
      endcase
      // ids mostly in the range the table can hold, so matches are common
      if (mix != 3 && $urandom_range(0, 99) < 85) tid = 8'($urandom_range(0, MAX_ENTRIES + 1));
      else tid = 8'($urandom);
      roll = $urandom_range(0, 9);
      rt = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hffff : 16'($urandom);
      queue_cmd(c, tid, rt, no_gaps ? 0 : pick_gap());
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while ((cmd_queue.size() != 0 || start || expected_results.size() != 0)
           && idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
    end

    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
    end else begin
      repeat (2 * MAX_ENTRIES + 4) @(posedge clk);
      if (error_count == 0 && expected_results.size() == 0) begin
        $display("TEST PASSED");
      end else begin
        $display("TEST FAILED");
      end
    end
    $finish;
  end

endmodule
